>>> hdl/lmat_pkg.sv
// Shared constants, types and helper functions for the local mean adaptive threshold block.
package lmat_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int RADIUS    = 7;
	localparam int SPAN      = 2 * RADIUS + 1;
	localparam int PIX_MAX   = 255;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 12;
	localparam int REG_IDX_W = 4;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = CFG_W + 1;
	localparam int SLOT_W    = $clog2(SPAN);
	localparam int LS_DEPTH  = SPAN * MAX_WIDTH;
	localparam int LS_AW     = SLOT_W + COL_W;
	localparam int CS_SUM_W  = $clog2(SPAN * PIX_MAX + 1);
	localparam int CS_CNT_W  = $clog2(SPAN + 1);
	localparam int WS_W      = $clog2(SPAN * SPAN * PIX_MAX + 1);
	localparam int WC_W      = $clog2(SPAN * SPAN + 1);
	localparam int PROD_W    = PIX_W + WC_W;
	localparam int DLY_W     = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);

	localparam int Q_DEPTH   = 8;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = REG_IDX_W'(1);

	localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1024);
	localparam logic [PIX_W-1:0] WHITE      = PIX_W'(PIX_MAX);

	typedef struct packed {
		logic [CS_CNT_W-1:0] cnt;
		logic [CS_SUM_W-1:0] sum;
	} colsum_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             inner;
		logic [WS_W-1:0]  wsum;
		logic [WC_W-1:0]  wcnt;
		logic             last;
	} qent_t;

	function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) r = CFG_W'(1);
		else if (v > CFG_W'(MAX_WIDTH)) r = CFG_W'(MAX_WIDTH);
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] eff_height(input logic [CFG_W-1:0] v);
		return (v == '0) ? CFG_W'(1) : v;
	endfunction

	function automatic logic [DLY_W-1:0] delay_of(input logic [CFG_W-1:0] ew);
		return DLY_W'(ew) * DLY_W'(RADIUS) + DLY_W'(RADIUS);
	endfunction

endpackage

>>> hdl/lmat_fifo.sv
// Short queue between the window front end and the decision back end.
module lmat_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  lmat_pkg::qent_t               din,
	input  logic                          pop,
	output lmat_pkg::qent_t               dout,
	output logic                          empty,
	output logic [lmat_pkg::Q_CNT_W-1:0]  count
);

	lmat_pkg::qent_t                 mem_q [lmat_pkg::Q_DEPTH];
	logic [lmat_pkg::Q_PTR_W-1:0]    wr_q;
	logic [lmat_pkg::Q_PTR_W-1:0]    rd_q;
	logic [lmat_pkg::Q_CNT_W-1:0]    cnt_q;

	assign dout  = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + lmat_pkg::Q_PTR_W'(1);
			if (pop) rd_q <= rd_q + lmat_pkg::Q_PTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + lmat_pkg::Q_CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - lmat_pkg::Q_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

endmodule

>>> hdl/lmat_front.sv
// Front end: config, frame counters, line store, running column and window sums.
module lmat_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lmat_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  logic [lmat_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lmat_pkg::PIX_W-1:0]      s_tdata,
	input  logic                            s_tuser,
	input  logic [lmat_pkg::Q_CNT_W-1:0]    q_count,
	output logic                            push,
	output lmat_pkg::qent_t                 push_data
);

	localparam int CW = lmat_pkg::CFG_W;

	// configuration
	logic [CW-1:0]                w_q;
	logic [CW-1:0]                h_q;
	logic [lmat_pkg::DLY_W-1:0]   dly_q;
	logic                         restart;

	// input and output positions
	logic [lmat_pkg::COL_W-1:0]   col_q;
	logic [lmat_pkg::ROW_W-1:0]   row_q;
	logic [lmat_pkg::SLOT_W-1:0]  slot_q;
	logic [lmat_pkg::DLY_W-1:0]   pre_q;
	logic                         on_q;
	logic [lmat_pkg::COL_W-1:0]   ox_q;
	logic [CW-1:0]                oy_q;
	logic [lmat_pkg::SLOT_W-1:0]  oslot_q;

	logic acc, wr, has_out, col_end, ox_end, last, inner;
	logic [lmat_pkg::PIX_W-1:0]   new_pix;

	// memories
	logic [lmat_pkg::PIX_W-1:0]   ls_mem [lmat_pkg::LS_DEPTH];
	lmat_pkg::colsum_t            cs_mem [lmat_pkg::MAX_WIDTH];
	logic [lmat_pkg::LS_AW-1:0]   wr_addr, cen_addr;

	// stage 1
	logic                         wr_s1, out_s1;
	logic [lmat_pkg::COL_W-1:0]   col_s1;
	logic [lmat_pkg::PIX_W-1:0]   new_s1, old_s1, cen_s1;
	logic                         rz_s1, ro_s1, cz_s1, cg_s1, int_s1, last_s1;
	lmat_pkg::colsum_t            cs_rd_s1;
	lmat_pkg::colsum_t            cs_base, cs_new;
	logic [lmat_pkg::PIX_W-1:0]   old_pix;

	// last column-sum write, for back-to-back hits on one column
	logic                         lw_v_q;
	logic [lmat_pkg::COL_W-1:0]   lw_addr_q;
	lmat_pkg::colsum_t            lw_data_q;

	// stage 2
	logic                         wr_s2, out_s2;
	lmat_pkg::colsum_t            cs_s2;
	logic                         cz_s2, cg_s2, int_s2, last_s2;
	logic [lmat_pkg::PIX_W-1:0]   cen_s2;

	// running window
	lmat_pkg::colsum_t            sh_q [lmat_pkg::SPAN];
	logic [lmat_pkg::WS_W-1:0]    ws_q;
	logic [lmat_pkg::WC_W-1:0]    wc_q;

	// stage 3
	logic                         out_s3, int_s3, last_s3;
	logic [lmat_pkg::PIX_W-1:0]   cen_s3;

	assign restart = cfg_we &&
		(cfg_addr == lmat_pkg::REG_FRAME_WIDTH || cfg_addr == lmat_pkg::REG_FRAME_HEIGHT);

	assign s_tready = (q_count + lmat_pkg::Q_CNT_W'(out_s1) + lmat_pkg::Q_CNT_W'(out_s2)
		+ lmat_pkg::Q_CNT_W'(out_s3)) < lmat_pkg::Q_CNT_W'(lmat_pkg::Q_DEPTH);
	assign acc = s_tvalid && s_tready;

	assign wr      = row_q < {1'b0, h_q};
	assign has_out = on_q || (pre_q == dly_q);
	assign col_end = ({1'b0, col_q} + CW'(1)) == w_q;
	assign ox_end  = ({1'b0, ox_q} + CW'(1)) == w_q;
	assign last    = has_out && ox_end && ((oy_q + CW'(1)) == h_q);
	assign inner   = (oy_q >= CW'(lmat_pkg::RADIUS)) && (ox_q >= lmat_pkg::COL_W'(lmat_pkg::RADIUS))
		&& (({1'b0, oy_q} + lmat_pkg::ROW_W'(lmat_pkg::RADIUS)) < {1'b0, h_q})
		&& (({1'b0, ox_q} + CW'(lmat_pkg::RADIUS)) < w_q);
	assign new_pix  = s_tuser ? '0 : s_tdata;
	assign wr_addr  = {slot_q, col_q};
	assign cen_addr = {oslot_q, ox_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= lmat_pkg::SIZE_RESET;
			h_q   <= lmat_pkg::SIZE_RESET;
			dly_q <= lmat_pkg::delay_of(lmat_pkg::SIZE_RESET);
		end else if (cfg_we) begin
			case (cfg_addr)
				lmat_pkg::REG_FRAME_WIDTH: begin
					w_q   <= lmat_pkg::eff_width(cfg_wdata);
					dly_q <= lmat_pkg::delay_of(lmat_pkg::eff_width(cfg_wdata));
				end
				lmat_pkg::REG_FRAME_HEIGHT: begin
					h_q <= lmat_pkg::eff_height(cfg_wdata);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slot_q  <= '0;
			pre_q   <= '0;
			on_q    <= 1'b0;
			ox_q    <= '0;
			oy_q    <= '0;
			oslot_q <= '0;
		end else if (restart || (acc && last)) begin
			col_q   <= '0;
			row_q   <= '0;
			slot_q  <= '0;
			pre_q   <= '0;
			on_q    <= 1'b0;
			ox_q    <= '0;
			oy_q    <= '0;
			oslot_q <= '0;
		end else if (acc) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_q + lmat_pkg::ROW_W'(1);
				if (slot_q == lmat_pkg::SLOT_W'(lmat_pkg::SPAN - 1)) slot_q <= '0;
				else slot_q <= slot_q + lmat_pkg::SLOT_W'(1);
			end else begin
				col_q <= col_q + lmat_pkg::COL_W'(1);
			end
			if (!on_q) begin
				if (pre_q == dly_q) on_q <= 1'b1;
				else pre_q <= pre_q + lmat_pkg::DLY_W'(1);
			end
			if (has_out) begin
				if (ox_end) begin
					ox_q <= '0;
					oy_q <= oy_q + CW'(1);
					if (oslot_q == lmat_pkg::SLOT_W'(lmat_pkg::SPAN - 1)) oslot_q <= '0;
					else oslot_q <= oslot_q + lmat_pkg::SLOT_W'(1);
				end else begin
					ox_q <= ox_q + lmat_pkg::COL_W'(1);
				end
			end
		end
	end

	// line store: read-first at the write address, second read at the window center
	always_ff @(posedge clk) begin
		old_s1 <= ls_mem[wr_addr];
		if (acc && wr) ls_mem[wr_addr] <= new_pix;
	end

	always_ff @(posedge clk) begin
		cen_s1 <= ls_mem[cen_addr];
	end

	// column sums
	assign old_pix = ro_s1 ? old_s1 : '0;
	always_comb begin
		if (rz_s1) cs_base = '0;
		else if (lw_v_q && (lw_addr_q == col_s1)) cs_base = lw_data_q;
		else cs_base = cs_rd_s1;
		cs_new.sum = cs_base.sum + lmat_pkg::CS_SUM_W'(new_s1) - lmat_pkg::CS_SUM_W'(old_pix);
		cs_new.cnt = cs_base.cnt + lmat_pkg::CS_CNT_W'(new_s1 != '0)
			- lmat_pkg::CS_CNT_W'(old_pix != '0);
	end

	always_ff @(posedge clk) begin
		cs_rd_s1 <= cs_mem[col_q];
		if (wr_s1) cs_mem[col_s1] <= cs_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_v_q <= 1'b0;
		end else if (wr_s1) begin
			lw_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_s1) begin
			lw_addr_q <= col_s1;
			lw_data_q <= cs_new;
		end
	end

	// stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1  <= 1'b0;
			out_s1 <= 1'b0;
			wr_s2  <= 1'b0;
			out_s2 <= 1'b0;
			out_s3 <= 1'b0;
		end else begin
			wr_s1  <= acc && wr;
			out_s1 <= acc && has_out;
			wr_s2  <= wr_s1;
			out_s2 <= out_s1;
			out_s3 <= out_s2;
		end
	end

	always_ff @(posedge clk) begin
		col_s1  <= col_q;
		new_s1  <= new_pix;
		rz_s1   <= (row_q == '0);
		ro_s1   <= (row_q >= lmat_pkg::ROW_W'(lmat_pkg::SPAN));
		cz_s1   <= (col_q == '0);
		cg_s1   <= (col_q >= lmat_pkg::COL_W'(lmat_pkg::SPAN));
		int_s1  <= inner;
		last_s1 <= last;

		cs_s2   <= cs_new;
		cz_s2   <= cz_s1;
		cg_s2   <= cg_s1;
		int_s2  <= int_s1;
		last_s2 <= last_s1;
		cen_s2  <= cen_s1;

		int_s3  <= int_s2;
		last_s3 <= last_s2;
		cen_s3  <= cen_s2;
	end

	// sliding window over the last SPAN column sums of the current row
	always_ff @(posedge clk) begin
		if (wr_s2) begin
			ws_q <= (cz_s2 ? '0 : ws_q) + lmat_pkg::WS_W'(cs_s2.sum)
				- (cg_s2 ? lmat_pkg::WS_W'(sh_q[lmat_pkg::SPAN-1].sum) : '0);
			wc_q <= (cz_s2 ? '0 : wc_q) + lmat_pkg::WC_W'(cs_s2.cnt)
				- (cg_s2 ? lmat_pkg::WC_W'(sh_q[lmat_pkg::SPAN-1].cnt) : '0);
			sh_q[0] <= cs_s2;
			for (int i = 1; i < lmat_pkg::SPAN; i++) sh_q[i] <= sh_q[i-1];
		end
	end

	assign push            = out_s3;
	assign push_data.pix   = cen_s3;
	assign push_data.inner = int_s3;
	assign push_data.wsum  = ws_q;
	assign push_data.wcnt  = wc_q;
	assign push_data.last  = last_s3;

endmodule

>>> hdl/lmat_back.sv
// Back end: mean comparison and registered output beat.
module lmat_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lmat_pkg::qent_t               q_data,
	input  logic                          q_empty,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lmat_pkg::PIX_W-1:0]    m_tdata,
	output logic                          m_tlast
);

	logic                          v_s1;
	logic [lmat_pkg::PIX_W-1:0]    pix_s1;
	logic                          inner_s1, last_s1;
	logic [lmat_pkg::PROD_W-1:0]   prod_s1;
	logic [lmat_pkg::WS_W-1:0]     wsum_s1;
	logic                          out_take, s1_rdy;
	logic [lmat_pkg::PIX_W-1:0]    result;

	assign out_take = !m_tvalid || m_tready;
	assign s1_rdy   = !v_s1 || out_take;
	assign q_pop    = !q_empty && s1_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_rdy) begin
			v_s1 <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pix_s1   <= q_data.pix;
			inner_s1 <= q_data.inner;
			last_s1  <= q_data.last;
			wsum_s1  <= q_data.wsum;
			prod_s1  <= lmat_pkg::PROD_W'(q_data.pix) * lmat_pkg::PROD_W'(q_data.wcnt);
		end
	end

	always_comb begin
		if (!inner_s1 || pix_s1 == '0) result = pix_s1;
		else if (lmat_pkg::WS_W'(prod_s1) < wsum_s1) result = '0;
		else result = lmat_pkg::WHITE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_take) begin
			m_tvalid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && v_s1) begin
			m_tdata <= result;
			m_tlast <= last_s1;
		end
	end

endmodule

>>> hdl/local_mean_adaptive_threshold.sv
// Local mean adaptive threshold, 15x15 window, top level.
//
// Config: cfg_we/cfg_addr/cfg_wdata write frame_width (index 0) or frame_height (index 1);
// either write restarts the frame at pixel zero. Write only while the block is idle.
// Input: one pixel per beat in raster order on s_tdata; s_tuser = 1 marks a flush beat
// that stands for a zero pixel inside a frame and only advances the delay after it.
// Output: m_tdata is the thresholded pixel (0 or 255, or the pixel itself for zero and
// border pixels), m_tlast marks the last pixel of the frame.
// A result belongs to the input beat 7 rows plus 7 pixels earlier; it shows on m_tvalid
// once the beat that completes its window has passed 3 front stages, queue and compare.
// Throughput is one beat per cycle while s_tready is high; per beat the line store takes
// one write and two reads, the column sum memory one read and one write, and the window
// sum updates in one stage. An 8-entry queue parts the front from the output; s_tready
// drops only when the queue plus beats in flight could overflow it, so a stalled receiver
// stops input after a few beats and nothing is lost. Reset clears counters and sets both
// sizes to 1024; memory contents are not cleared and need no clearing pass.
module local_mean_adaptive_threshold (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lmat_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  logic [lmat_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lmat_pkg::PIX_W-1:0]      s_tdata,   // [7:0] pixel_in
	input  logic [0:0]                      s_tuser,   // [0] req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lmat_pkg::PIX_W-1:0]      m_tdata,   // [7:0] pixel_out
	output logic                            m_tlast
);

	logic                          push, pop, empty;
	lmat_pkg::qent_t               push_data, q_data;
	logic [lmat_pkg::Q_CNT_W-1:0]  q_count;

	lmat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser[0]),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	lmat_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.pop    (pop),
		.dout   (q_data),
		.empty  (empty),
		.count  (q_count)
	);

	lmat_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_data   (q_data),
		.q_empty  (empty),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> tb/local_mean_adaptive_threshold_tb.sv
// Self-checking testbench for the 15x15 local mean adaptive threshold stream block.
module local_mean_adaptive_threshold_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BEATS = 1250;
	localparam int SETTLE       = 20;

	typedef struct packed {
		logic [lmat_pkg::PIX_W-1:0] pixel_out;
		logic                       frame_last;
	} thr_result_t;

	typedef struct packed {
		logic                       lead_flush;
		logic [lmat_pkg::PIX_W-1:0] lead_pix;
		logic                       fill_flush;
		logic [lmat_pkg::PIX_W-1:0] fill_pix;
		logic [lmat_pkg::PIX_W-1:0] exp_pix;
	} probe_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [lmat_pkg::REG_IDX_W-1:0] cfg_addr = '0;
	logic [lmat_pkg::CFG_W-1:0]     cfg_wdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [lmat_pkg::PIX_W-1:0]     s_tdata = '0;
	logic [0:0]                     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [lmat_pkg::PIX_W-1:0]     m_tdata;
	logic                           m_tlast;

	// 1x1 frames: one lead beat, then fillers until its result drains out
	probe_row_t probe_rows [0:7] = '{
		'{1'b0, 8'h00, 1'b1, 8'hff, 8'h00},
		'{1'b0, 8'hff, 1'b1, 8'h00, 8'hff},
		'{1'b0, 8'h01, 1'b0, 8'hfe, 8'h01},
		'{1'b0, 8'h80, 1'b0, 8'h7f, 8'h80},
		'{1'b0, 8'h7f, 1'b1, 8'h80, 8'h7f},
		'{1'b1, 8'hff, 1'b0, 8'hff, 8'h00},
		'{1'b1, 8'h5a, 1'b1, 8'ha5, 8'h00},
		'{1'b0, 8'haa, 1'b0, 8'h55, 8'haa}
	};

	thr_result_t                expected_results [$];
	logic [lmat_pkg::PIX_W-1:0] pixel_rows [lmat_pkg::SPAN*lmat_pkg::MAX_WIDTH];
	logic [lmat_pkg::CFG_W-1:0] width_reg;
	logic [lmat_pkg::CFG_W-1:0] height_reg;
	int unsigned                row_pos;
	int unsigned                col_pos;
	int                         beats_sent = 0;
	int                         fail_count = 0;
	bit                         stall_on = 1'b1;

	local_mean_adaptive_threshold i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= !stall_on || ($urandom_range(99) >= 35);
	end

	always @(posedge clk) begin
		thr_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected beat: pixel_out %0d frame_last %0d", m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_tdata !== want.pixel_out) begin
					$error("pixel_out mismatch: expected %0d, actual %0d", want.pixel_out, m_tdata);
					fail_count++;
				end
				if (m_tlast !== want.frame_last) begin
					$error("frame_last mismatch: expected %0d, actual %0d", want.frame_last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	function automatic int unsigned clamp_width(input logic [lmat_pkg::CFG_W-1:0] v);
		if (v == '0) return 1;
		if (v > lmat_pkg::CFG_W'(lmat_pkg::MAX_WIDTH)) return lmat_pkg::MAX_WIDTH;
		return 32'(v);
	endfunction

	function automatic int unsigned clamp_height(input logic [lmat_pkg::CFG_W-1:0] v);
		return (v == '0) ? 1 : 32'(v);
	endfunction

	function automatic logic [lmat_pkg::PIX_W-1:0] window_decision(input int unsigned y,
			input int unsigned x, input int unsigned w, input int unsigned h);
		int unsigned center;
		int unsigned acc_sum;
		int unsigned acc_cnt;
		int unsigned p;
		center = pixel_rows[(y % lmat_pkg::SPAN) * lmat_pkg::MAX_WIDTH
			+ (x % lmat_pkg::MAX_WIDTH)];
		acc_sum = 0;
		acc_cnt = 0;
		if (center == 0) return '0;
		if (y < lmat_pkg::RADIUS || x < lmat_pkg::RADIUS || y + lmat_pkg::RADIUS >= h
			|| x + lmat_pkg::RADIUS >= w) return lmat_pkg::PIX_W'(center);
		for (int unsigned dy = 0; dy < lmat_pkg::SPAN; dy++) begin
			for (int unsigned dx = 0; dx < lmat_pkg::SPAN; dx++) begin
				p = pixel_rows[((y - lmat_pkg::RADIUS + dy) % lmat_pkg::SPAN) * lmat_pkg::MAX_WIDTH
					+ ((x - lmat_pkg::RADIUS + dx) % lmat_pkg::MAX_WIDTH)];
				if (p != 0) begin
					acc_sum += p;
					acc_cnt++;
				end
			end
		end
		return (center * acc_cnt < acc_sum) ? '0 : lmat_pkg::WHITE;
	endfunction

	task automatic predict_threshold(input logic flush, input logic [lmat_pkg::PIX_W-1:0] pix,
			output logic has_res, output thr_result_t res);
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int unsigned delay;
		int unsigned pos;
		int unsigned q;
		w = clamp_width(width_reg);
		h = clamp_height(height_reg);
		total = w * h;
		delay = lmat_pkg::RADIUS * w + lmat_pkg::RADIUS;
		has_res = 1'b0;
		res = '0;
		if (col_pos >= w) col_pos = 0;
		pos = row_pos * w + col_pos;
		if (pos < total)
			pixel_rows[(row_pos % lmat_pkg::SPAN) * lmat_pkg::MAX_WIDTH + col_pos] =
				flush ? '0 : pix;
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (pos >= delay) begin
			q = pos - delay;
			has_res = 1'b1;
			res.pixel_out = window_decision(q / w, q % w, w, h);
			res.frame_last = (q + 1 >= total);
			if (res.frame_last) begin
				row_pos = 0;
				col_pos = 0;
			end
		end
	endtask

	task automatic write_reg(input logic [lmat_pkg::REG_IDX_W-1:0] idx,
			input logic [lmat_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == lmat_pkg::REG_FRAME_WIDTH) begin
			width_reg = val;
			row_pos = 0;
			col_pos = 0;
		end else if (idx == lmat_pkg::REG_FRAME_HEIGHT) begin
			height_reg = val;
			row_pos = 0;
			col_pos = 0;
		end
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic send_beat(input logic flush, input logic [lmat_pkg::PIX_W-1:0] pix,
			input logic typed, input thr_result_t typed_res);
		logic has;
		thr_result_t res;
		while (stall_on && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= flush;
		s_tdata <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
		predict_threshold(flush, pix, has, res);
		if (has) expected_results.insert(expected_results.size(), typed ? typed_res : res);
		@(negedge clk);
	endtask

	// stop_at abandons the frame early; stray_at pauses and writes an unused register index
	task automatic run_frame(input logic [lmat_pkg::CFG_W-1:0] w_reg,
			input logic [lmat_pkg::CFG_W-1:0] h_reg, input int stop_at, input int stray_at);
		int total;
		int span_items;
		int mode;
		int zero_pct;
		int flush_pct;
		logic [lmat_pkg::PIX_W-1:0] base;
		logic [lmat_pkg::PIX_W-1:0] pix;
		logic flush;
		drain_results();
		write_reg(lmat_pkg::REG_FRAME_WIDTH, w_reg);
		write_reg(lmat_pkg::REG_FRAME_HEIGHT, h_reg);
		total = clamp_width(w_reg) * clamp_height(h_reg);
		span_items = total + lmat_pkg::RADIUS * clamp_width(w_reg) + lmat_pkg::RADIUS;
		mode = $urandom_range(2);
		zero_pct = $urandom_range(40);
		flush_pct = $urandom_range(8);
		base = lmat_pkg::PIX_W'($urandom_range(215, 40));
		for (int n = 0; n < span_items; n++) begin
			if (n == stop_at) break;
			if (n == stray_at) begin
				drain_results();
				write_reg(lmat_pkg::REG_IDX_W'($urandom_range(15, 2)), lmat_pkg::CFG_W'($urandom));
			end
			if (n < total) begin
				flush = ($urandom_range(99) < flush_pct);
				if ($urandom_range(99) < zero_pct) pix = '0;
				else begin
					case (mode)
						0: pix = lmat_pkg::PIX_W'($urandom);
						1: pix = base;
						default: pix = base + lmat_pkg::PIX_W'($urandom_range(40))
							- lmat_pkg::PIX_W'(20);
					endcase
				end
			end else begin
				flush = 1'($urandom_range(1));
				pix = lmat_pkg::PIX_W'($urandom);
			end
			send_beat(flush, pix, 1'b0, '0);
		end
	endtask

	initial begin
		thr_result_t typed_res;
		int start;
		int frame_no;
		int pick;
		logic [lmat_pkg::CFG_W-1:0] fw;
		logic [lmat_pkg::CFG_W-1:0] fh;
		for (int i = 0; i < lmat_pkg::SPAN * lmat_pkg::MAX_WIDTH; i++) pixel_rows[i] = '0;
		width_reg = lmat_pkg::SIZE_RESET;
		height_reg = lmat_pkg::SIZE_RESET;
		row_pos = 0;
		col_pos = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero sizes count as 1x1
		write_reg(lmat_pkg::REG_FRAME_WIDTH, '0);
		write_reg(lmat_pkg::REG_FRAME_HEIGHT, '0);
		foreach (probe_rows[i]) begin
			typed_res.pixel_out = probe_rows[i].exp_pix;
			typed_res.frame_last = 1'b1;
			// a 1x1 frame needs one pixel plus 14 fillers
			for (int k = 0; k < lmat_pkg::SPAN; k++) begin
				if (k == 0) send_beat(probe_rows[i].lead_flush, probe_rows[i].lead_pix, 1'b0, '0);
				else send_beat(probe_rows[i].fill_flush, probe_rows[i].fill_pix,
					k == lmat_pkg::SPAN - 1, typed_res);
			end
		end

		start = beats_sent;
		frame_no = 0;
		while (beats_sent - start < RANDOM_BEATS) begin
			stall_on = (frame_no != 2);
			pick = $urandom_range(99);
			fw = lmat_pkg::CFG_W'($urandom_range(22, 15));
			fh = lmat_pkg::CFG_W'($urandom_range(18, 15));
			if (frame_no == 0)
				run_frame(fw, fh, -1, $urandom_range(250, 1));
			else if (frame_no == 1)
				run_frame(fw, fh, $urandom_range(300, 1), -1);
			else if (frame_no == 2 || pick < 65)
				run_frame(fw, fh, -1, -1);
			else if (pick < 82)
				run_frame(lmat_pkg::CFG_W'($urandom_range(14, 1)),
					lmat_pkg::CFG_W'($urandom_range(14, 1)), -1, -1);
			else if (pick < 91)
				run_frame(fw, fh, $urandom_range(300, 1), -1);
			else
				run_frame(fw, fh, -1, $urandom_range(250, 1));
			frame_no++;
		end

		// widest frame (clamped) and tallest frame, both cut short
		stall_on = 1'b1;
		run_frame('1, '0, 100, -1);
		stall_on = 1'b0;
		run_frame(lmat_pkg::CFG_W'(1), '1, 200, -1);
		stall_on = 1'b1;

		drain_results();
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
